// ===== src/cpa_pkg.sv =====
// shared types and constants of the color pair allocator
package cpa_pkg;

    localparam int CODE_W = 9;
    localparam int KEY_W  = 2 * CODE_W;

    typedef logic [1:0]        t_kind;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [KEY_W-1:0]  t_key;

    localparam t_kind KIND_INDEXED = 2'd0;
    localparam t_kind KIND_RGB     = 2'd1;
    localparam t_kind KIND_OTHER   = 2'd2;

    localparam t_code CODE_NONE = 9'h1FF;

    // token handed from one cell to the next
    typedef struct packed {
        logic pass;
        t_key key;
    } t_tok;

endpackage

// ===== src/color_pair_allocator_core.sv =====
// top level of the color pair allocator
// One item at a time. A word is taken, its two colors are quantized in the next cycle, and the
// (fg,bg) key then walks the chain of table cells one slot per cycle from slot 1 until it hits
// a matching slot, the first free slot (where it is stored), or runs off the last slot (table
// full). The time from acceptance to result grows with the slot at which the walk stops. A new
// word is accepted while a finished result still waits in the output register.
module color_pair_allocator_core #(
    parameter int TABLE_SIZE = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cpa_pkg::t_kind    i_fg_kind,
    input  logic [7:0]        i_fg_index,
    input  logic [7:0]        i_fg_red,
    input  logic [7:0]        i_fg_green,
    input  logic [7:0]        i_fg_blue,
    input  cpa_pkg::t_kind    i_bg_kind,
    input  logic [7:0]        i_bg_index,
    input  logic [7:0]        i_bg_red,
    input  logic [7:0]        i_bg_green,
    input  logic [7:0]        i_bg_blue,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_pair_number,
    output logic signed [8:0] o_fg_code,
    output logic signed [8:0] o_bg_code,
    output logic              o_new_pair,
    output logic              o_table_full
);

    localparam int SlotW = $clog2(TABLE_SIZE + 1);
    localparam int LastSlot = TABLE_SIZE - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUANT,
        ST_SEARCH,
        ST_SEND
    } t_state;

    t_state r_state;

    cpa_pkg::t_kind r_fg_kind, r_bg_kind;
    logic [7:0] r_fg_index, r_fg_red, r_fg_green, r_fg_blue;
    logic [7:0] r_bg_index, r_bg_red, r_bg_green, r_bg_blue;

    cpa_pkg::t_code fg_q, bg_q;
    cpa_pkg::t_code r_fg_code, r_bg_code;

    logic [SlotW-1:0] r_pos;
    logic [SlotW-1:0] r_next_free;

    logic [7:0] r_res_slot;
    logic       r_res_new;
    logic       r_res_full;

    logic              r_out_v;
    logic [7:0]        r_out_slot;
    cpa_pkg::t_code    r_out_fg, r_out_bg;
    logic              r_out_new;
    logic              r_out_full;
    logic              send_load;

    cpa_pkg::t_tok        chain [1:TABLE_SIZE];
    logic [LastSlot:1]    match_vec;
    logic                 any_match;

    cpa_quant u_fg_quant (
        .i_kind (r_fg_kind),
        .i_index(r_fg_index),
        .i_red  (r_fg_red),
        .i_green(r_fg_green),
        .i_blue (r_fg_blue),
        .o_code (fg_q)
    );

    cpa_quant u_bg_quant (
        .i_kind (r_bg_kind),
        .i_index(r_bg_index),
        .i_red  (r_bg_red),
        .i_green(r_bg_green),
        .i_blue (r_bg_blue),
        .o_code (bg_q)
    );

    // the key enters slot 1 right after quantization
    assign chain[1].pass = (r_state == ST_QUANT);
    assign chain[1].key  = {fg_q, bg_q};

    for (genvar g = 1; g < TABLE_SIZE; g++) begin : g_cell
        cpa_cell #(
            .CELL_INDEX(g),
            .SLOT_W    (SlotW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (chain[g]),
            .i_next_free(r_next_free),
            .o_tok      (chain[g+1]),
            .o_match    (match_vec[g])
        );
    end

    assign any_match = |match_vec;

    // output register takes the finished result once it is free or being drained
    assign send_load = (r_state == ST_SEND) && (!r_out_v || i_ready);

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_v;
    assign o_pair_number = r_out_slot;
    assign o_fg_code     = r_out_fg;
    assign o_bg_code     = r_out_bg;
    assign o_new_pair    = r_out_new;
    assign o_table_full  = r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_v     <= 1'b0;
            r_next_free <= SlotW'(1);
        end else begin
            if (send_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_fg_kind  <= i_fg_kind;
                        r_fg_index <= i_fg_index;
                        r_fg_red   <= i_fg_red;
                        r_fg_green <= i_fg_green;
                        r_fg_blue  <= i_fg_blue;
                        r_bg_kind  <= i_bg_kind;
                        r_bg_index <= i_bg_index;
                        r_bg_red   <= i_bg_red;
                        r_bg_green <= i_bg_green;
                        r_bg_blue  <= i_bg_blue;
                        r_state    <= ST_QUANT;
                    end
                end
                ST_QUANT: begin
                    r_fg_code <= fg_q;
                    r_bg_code <= bg_q;
                    r_pos     <= SlotW'(1);
                    r_state   <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    priority if (any_match) begin
                        r_res_slot <= 8'(r_pos);
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b0;
                        r_state    <= ST_SEND;
                    end else if (r_pos == r_next_free) begin
                        r_res_slot  <= 8'(r_pos);
                        r_res_new   <= 1'b1;
                        r_res_full  <= 1'b0;
                        r_next_free <= r_next_free + SlotW'(1);
                        r_state     <= ST_SEND;
                    end else if (chain[TABLE_SIZE].pass) begin
                        // walked past the last slot without a match
                        r_res_slot <= 8'd0;
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b1;
                        r_state    <= ST_SEND;
                    end else begin
                        r_pos <= r_pos + SlotW'(1);
                    end
                end
                ST_SEND: begin
                    if (send_load) begin
                        r_out_slot <= r_res_slot;
                        r_out_fg   <= r_fg_code;
                        r_out_bg   <= r_bg_code;
                        r_out_new  <= r_res_new;
                        r_out_full <= r_res_full;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/cpa_quant.sv =====
// maps one indexed or rgb color to its 256-color palette code, any other kind to CODE_NONE
module cpa_quant (
    input  cpa_pkg::t_kind i_kind,
    input  logic [7:0]     i_index,
    input  logic [7:0]     i_red,
    input  logic [7:0]     i_green,
    input  logic [7:0]     i_blue,
    output cpa_pkg::t_code o_code
);

    // v*5/255 as a ladder of thresholds
    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] lvl;
        begin
            lvl = 3'd0;
            if (v >= 8'd51)  lvl = 3'd1;
            if (v >= 8'd102) lvl = 3'd2;
            if (v >= 8'd153) lvl = 3'd3;
            if (v >= 8'd204) lvl = 3'd4;
            if (v == 8'd255) lvl = 3'd5;
            cube_level = lvl;
        end
    endfunction

    logic [7:0]  gray_x;
    logic [15:0] gray_prod;
    logic [4:0]  gray_q;
    logic [8:0]  gray_sum;
    logic [7:0]  gray_code;
    logic [7:0]  cube_code;
    logic [7:0]  rgb_code;

    always_comb begin
        gray_x    = i_red - 8'd8;
        // divide by 10 through the reciprocal 205/2048
        gray_prod = 16'(gray_x) * 16'd205;
        gray_q    = gray_prod[15:11];
        gray_sum  = 9'd232 + 9'(gray_q);
        gray_code = gray_sum[8] ? 8'd255 : gray_sum[7:0];
        if (i_red < 8'd8) begin
            gray_code = 8'd16;
        end else if (i_red > 8'd248) begin
            gray_code = 8'd231;
        end
        cube_code = 8'd16 + 8'd36 * 8'(cube_level(i_red))
                  + 8'd6 * 8'(cube_level(i_green)) + 8'(cube_level(i_blue));
        rgb_code  = (i_red == i_green && i_green == i_blue) ? gray_code : cube_code;
    end

    always_comb begin
        unique case (i_kind)
            cpa_pkg::KIND_INDEXED: o_code = {1'b0, i_index};
            cpa_pkg::KIND_RGB:     o_code = {1'b0, rgb_code};
            default:               o_code = cpa_pkg::CODE_NONE;
        endcase
    end

endmodule

// ===== src/cpa_cell.sv =====
// one slot of the pair table: holds a stored pair and checks the passing key
module cpa_cell #(
    parameter int CELL_INDEX = 1,
    parameter int SLOT_W     = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpa_pkg::t_tok     i_tok,
    input  logic [SLOT_W-1:0] i_next_free,
    output cpa_pkg::t_tok     o_tok,
    output logic              o_match
);

    localparam logic [SLOT_W-1:0] MyIndex = SLOT_W'(CELL_INDEX);

    logic          r_tok_v;
    cpa_pkg::t_key r_key;
    cpa_pkg::t_key r_entry;
    logic          occupied;
    logic          write_en;

    assign occupied = MyIndex < i_next_free;
    assign write_en = r_tok_v && (MyIndex == i_next_free);
    assign o_match  = r_tok_v && occupied && (r_entry == r_key);
    // token moves on only past a filled slot that does not match
    assign o_tok.pass = r_tok_v && occupied && (r_entry != r_key);
    assign o_tok.key  = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_v <= 1'b0;
        end else begin
            r_tok_v <= i_tok.pass;
        end
        if (i_tok.pass) begin
            r_key <= i_tok.key;
        end
        if (write_en) begin
            r_entry <= r_key;
        end
    end

endmodule

// ===== src/cpa_checker.sv =====
// port-level checks of the color pair allocator, bound to the top level
module cpa_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [7:0]        o_pair_number,
    input logic              o_new_pair,
    input logic              o_table_full
);

    // new slot and full table exclude each other
    a_new_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_new_pair && o_table_full))
        else $error("new_pair and table_full both set");

    // a full table always reports the reserved slot
    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_pair_number == 8'd0))
        else $error("table_full with nonzero pair number");

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while previous word still in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pair_number)))
        else $error("stalled result changed");

endmodule

bind color_pair_allocator_core cpa_checker u_cpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pair_number(o_pair_number),
    .o_new_pair   (o_new_pair),
    .o_table_full (o_table_full)
);

// ===== tb/color_pair_allocator_core_tb.sv =====
// self-checking testbench for the color pair allocator core
`timescale 1ns / 100ps

module color_pair_allocator_core_tb;

    localparam int TABLE_SIZE = 255;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int MAX_REPORTS = 10;
    // kind encoding with no name in the package, quantized like other
    localparam cpa_pkg::t_kind KIND_RESERVED = 2'd3;

    typedef struct packed {
        cpa_pkg::t_kind kind;
        logic [7:0]     index;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
    } t_color;

    typedef struct packed {
        t_color fg;
        t_color bg;
    } t_cell;

    typedef struct packed {
        logic [7:0]     pair_number;
        cpa_pkg::t_code fg_code;
        cpa_pkg::t_code bg_code;
        logic           new_pair;
        logic           table_full;
    } t_pair_result;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic cell_valid = 1'b0;
    t_cell cell_word = '0;
    logic pair_ready = 1'b0;

    logic              o_ready;
    logic              o_valid;
    logic [7:0]        o_pair_number;
    logic signed [8:0] o_fg_code;
    logic signed [8:0] o_bg_code;
    logic              o_new_pair;
    logic              o_table_full;

    t_cell cells_to_send[$];
    t_cell cells_seen[$];
    t_pair_result pair_results_due[$];

    // own copy of the pair table
    cpa_pkg::t_key stored_keys[TABLE_SIZE];
    int unsigned free_slot = 1;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int idle_cycles = 0;

    color_pair_allocator_core #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cell_valid),
        .o_ready      (o_ready),
        .i_fg_kind    (cell_word.fg.kind),
        .i_fg_index   (cell_word.fg.index),
        .i_fg_red     (cell_word.fg.red),
        .i_fg_green   (cell_word.fg.green),
        .i_fg_blue    (cell_word.fg.blue),
        .i_bg_kind    (cell_word.bg.kind),
        .i_bg_index   (cell_word.bg.index),
        .i_bg_red     (cell_word.bg.red),
        .i_bg_green   (cell_word.bg.green),
        .i_bg_blue    (cell_word.bg.blue),
        .o_valid      (o_valid),
        .i_ready      (pair_ready),
        .o_pair_number(o_pair_number),
        .o_fg_code    (o_fg_code),
        .o_bg_code    (o_bg_code),
        .o_new_pair   (o_new_pair),
        .o_table_full (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic cpa_pkg::t_code quantize_color(t_color c);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned q;
        r = c.red;
        g = c.green;
        b = c.blue;
        case (c.kind)
            cpa_pkg::KIND_INDEXED: return {1'b0, c.index};
            cpa_pkg::KIND_RGB: begin
                if (r == g && g == b) begin
                    if (r < 8)
                        q = 16;
                    else if (r > 248)
                        q = 231;
                    else
                        q = 232 + (r - 8) / 10;
                    // 248 lands one past the ramp
                    if (q > 255)
                        q = 255;
                end else begin
                    q = 16 + 36 * (r * 5 / 255) + 6 * (g * 5 / 255) + b * 5 / 255;
                end
                return q[cpa_pkg::CODE_W-1:0];
            end
            default: return cpa_pkg::CODE_NONE;
        endcase
    endfunction

    // look the pair up, append it if there is room, update the table copy
    function automatic t_pair_result allocate_pair(t_cell c);
        t_pair_result res;
        cpa_pkg::t_key key;
        int unsigned slot;
        bit found;
        res = '0;
        found = 1'b0;
        slot = 0;
        res.fg_code = quantize_color(c.fg);
        res.bg_code = quantize_color(c.bg);
        key = {res.fg_code, res.bg_code};
        for (int unsigned i = 1; i < free_slot && i < TABLE_SIZE; i++) begin
            if (!found && stored_keys[i] == key) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (free_slot >= TABLE_SIZE) begin
                res.table_full = 1'b1;
            end else begin
                slot = free_slot;
                stored_keys[slot] = key;
                free_slot++;
                res.new_pair = 1'b1;
            end
        end
        res.pair_number = slot[7:0];
        return res;
    endfunction

    function automatic t_color make_color(cpa_pkg::t_kind kind, logic [7:0] index,
                                          logic [7:0] red, logic [7:0] green,
                                          logic [7:0] blue);
        t_color c;
        c.kind = kind;
        c.index = index;
        c.red = red;
        c.green = green;
        c.blue = blue;
        return c;
    endfunction

    function automatic t_color gray(logic [7:0] v);
        return make_color(cpa_pkg::KIND_RGB, 8'd0, v, v, v);
    endfunction

    function automatic t_color indexed(logic [7:0] v);
        return make_color(cpa_pkg::KIND_INDEXED, v, 8'd0, 8'd0, 8'd0);
    endfunction

    function automatic t_color random_color();
        t_color c;
        int pick;
        c = make_color(cpa_pkg::KIND_INDEXED, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            c.kind = cpa_pkg::KIND_INDEXED;
        end else if (pick < 55) begin
            c.kind = cpa_pkg::KIND_RGB;
        end else if (pick < 70) begin
            // equal channels hit the gray ramp
            c.kind = cpa_pkg::KIND_RGB;
            c.green = c.red;
            c.blue = c.red;
        end else if (pick < 85) begin
            c.kind = cpa_pkg::KIND_OTHER;
        end else begin
            c.kind = KIND_RESERVED;
        end
        return c;
    endfunction

    // same code, fresh values in the fields the kind ignores
    function automatic t_color scramble_unused(t_color c);
        t_color n;
        n = c;
        if (c.kind != cpa_pkg::KIND_INDEXED)
            n.index = 8'($urandom_range(0, 255));
        if (c.kind != cpa_pkg::KIND_RGB) begin
            n.red = 8'($urandom_range(0, 255));
            n.green = 8'($urandom_range(0, 255));
            n.blue = 8'($urandom_range(0, 255));
        end
        return n;
    endfunction

    task automatic queue_cell(t_color fg, t_color bg);
        t_cell c;
        c.fg = fg;
        c.bg = bg;
        cells_to_send.push_back(c);
        cells_seen.push_back(c);
    endtask

    task automatic queue_random_cells(int count);
        t_cell c;
        repeat (count) begin
            if (cells_seen.size() != 0 && $urandom_range(0, 99) < 55) begin
                // revisit an earlier pair so the lookup finds a match
                c = cells_seen[$urandom_range(0, cells_seen.size() - 1)];
                queue_cell(scramble_unused(c.fg), scramble_unused(c.bg));
            end else begin
                queue_cell(random_color(), random_color());
            end
        end
    endtask

    task automatic queue_directed_cells();
        queue_cell(indexed(8'd0), indexed(8'd255));
        queue_cell(indexed(8'd255), indexed(8'd0));
        queue_cell(gray(8'd0), gray(8'd255));
        queue_cell(gray(8'd7), gray(8'd8));
        queue_cell(gray(8'd247), gray(8'd248));
        queue_cell(gray(8'd249), gray(8'd17));
        queue_cell(gray(8'd18), gray(8'd128));
        queue_cell(make_color(cpa_pkg::KIND_RGB, 8'hFF, 8'd255, 8'd0, 8'd0),
                   make_color(cpa_pkg::KIND_RGB, 8'h00, 8'd0, 8'd255, 8'd0));
        queue_cell(make_color(cpa_pkg::KIND_RGB, 8'd0, 8'd0, 8'd0, 8'd255),
                   make_color(cpa_pkg::KIND_RGB, 8'd0, 8'd51, 8'd102, 8'd153));
        queue_cell(make_color(cpa_pkg::KIND_RGB, 8'd0, 8'd254, 8'd255, 8'd255),
                   make_color(cpa_pkg::KIND_RGB, 8'd0, 8'd1, 8'd0, 8'd0));
        queue_cell(make_color(cpa_pkg::KIND_OTHER, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                   make_color(KIND_RESERVED, 8'h00, 8'h00, 8'h00, 8'h00));
        // other and reserved kinds give the same code, so this one matches
        queue_cell(make_color(KIND_RESERVED, 8'hA5, 8'h5A, 8'hC3, 8'h3C),
                   make_color(cpa_pkg::KIND_OTHER, 8'h5A, 8'hA5, 8'h3C, 8'hC3));
        queue_cell(indexed(8'd0), indexed(8'd255));
        queue_cell(indexed(8'd16), gray(8'd0));
        // gray below the ramp quantizes to the same code as index 16
        queue_cell(gray(8'd3), indexed(8'd16));
        queue_cell(indexed(8'd231), gray(8'd250));
        queue_cell(make_color(cpa_pkg::KIND_OTHER, 8'd0, 8'd0, 8'd0, 8'd0), indexed(8'd200));
        queue_cell(indexed(8'd200), make_color(KIND_RESERVED, 8'd0, 8'd0, 8'd0, 8'd0));
        queue_cell(make_color(cpa_pkg::KIND_INDEXED, 8'd128, 8'hFF, 8'hFF, 8'hFF),
                   make_color(cpa_pkg::KIND_RGB, 8'hFF, 8'd50, 8'd51, 8'd52));
    endtask

    task automatic wait_all_cells_done();
        while (cells_to_send.size() != 0 || cell_valid || pair_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_valid <= 1'b0;
        end else begin
            if (cell_valid && o_ready)
                pair_results_due.push_back(allocate_pair(cell_word));
            if (!cell_valid || o_ready) begin
                if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cell_word <= cells_to_send.pop_front();
                    cell_valid <= 1'b1;
                end else begin
                    cell_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_pair_result got;
        t_pair_result want;
        if (!i_rst_n) begin
            pair_ready <= 1'b0;
        end else begin
            pair_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (o_valid && pair_ready) begin
                got.pair_number = o_pair_number;
                got.fg_code = o_fg_code;
                got.bg_code = o_bg_code;
                got.new_pair = o_new_pair;
                got.table_full = o_table_full;
                if (pair_results_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected word: pair %0d fg %0d bg %0d new %0b full %0b",
                                 got.pair_number, $signed(got.fg_code),
                                 $signed(got.bg_code), got.new_pair, got.table_full);
                end else begin
                    want = pair_results_due.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch: expected pair %0d fg %0d bg %0d new %0b ",
                                      "full %0b, got pair %0d fg %0d bg %0d new %0b full %0b"},
                                     want.pair_number, $signed(want.fg_code),
                                     $signed(want.bg_code), want.new_pair, want.table_full,
                                     got.pair_number, $signed(got.fg_code),
                                     $signed(got.bg_code), got.new_pair, got.table_full);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((cell_valid && o_ready) || (o_valid && pair_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 0;
        recv_stall_pct = 0;
        queue_directed_cells();
        queue_random_cells(300);
        wait_all_cells_done();

        sender_idle_pct = 79;
        recv_stall_pct = 0;
        queue_random_cells(330);
        wait_all_cells_done();

        sender_idle_pct = 0;
        recv_stall_pct = 79;
        queue_random_cells(330);
        wait_all_cells_done();

        sender_idle_pct = 7;
        recv_stall_pct = 7;
        queue_random_cells(330);
        wait_all_cells_done();

        repeat (TABLE_SIZE + 10) @(posedge i_clk);
        errors += pair_results_due.size();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cpa_pkg.sv
src/cpa_quant.sv
src/cpa_cell.sv
src/color_pair_allocator_core.sv
src/cpa_checker.sv
tb/color_pair_allocator_core_tb.sv
